FILE: src/ssre_pkg.sv
package ssre_pkg;

    // Ring geometry
    localparam int DEPTH = 512;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // Port field widths
    localparam int VAL_W       = 32;
    localparam int FILL_W      = 10;
    localparam int IN_USER_W   = 3;
    localparam int OUT_USER_W  = 3;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_PAD_W   = OUT_DATA_W - VAL_W - FILL_W;

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SWAP = 3'd2,
        OP_ROT  = 3'd3,
        OP_RROT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // (base + pos) mod DEPTH, with base < DEPTH and pos <= DEPTH
    function automatic t_addr f_wrap(input t_addr base, input t_count pos);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, pos};
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

FILE: src/stack_swap_rotate_engine_top.sv
// Request accepted to result valid: push, pop, no-op and moves on fewer than two values go
// to S_FIN; rotate and reverse rotate pass S_MV_WR, swap passes S_SW_RD2, S_SW_WA and S_SW_WB,
// before S_FIN (one read, one write port on the slot RAM). The next request is taken once the
// result is loaded into the output register, even if unread.
// Reset (i_rst_n low, synchronous): stack empty, bottom at slot 0, output invalid.
// Slot RAM is not cleared; only written slots are ever read.
module stack_swap_rotate_engine_top
    import ssre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VAL_W-1:0]      i_s_tdata,   // [31:0] push_value
    input  logic [IN_USER_W-1:0]  i_s_tuser,   // [2:0] operation
    // result channel
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] popped_value, [41:32] fill_count
    output logic [OUT_USER_W-1:0] o_m_tuser    // [0] popped_valid, [2:1] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SW_RD2,   // swap: read second slot, hold top value
        S_SW_WA,    // swap: write second value into top slot
        S_SW_WB,    // swap: write top value into second slot
        S_MV_WR,    // rotate / reverse rotate: write moved value
        S_FIN       // load result register
    } t_state;

    // slot RAM: one write port, one registered read port
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    t_addr            mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    t_addr            mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    t_state            r_state,     n_state;
    t_addr             r_bottom,    n_bottom;
    t_count            r_count,     n_count;
    t_addr             r_addr_a,    n_addr_a;
    t_addr             r_addr_b,    n_addr_b;
    logic [VAL_W-1:0]  r_tmp,       n_tmp;
    t_status           r_status,    n_status;
    logic              r_pvalid,    n_pvalid;
    logic              r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;

    t_op   op;
    t_addr top_slot;
    logic  accept;
    logic  out_free;

    assign op       = t_op'(i_s_tuser);
    assign top_slot = f_wrap(r_bottom, t_count'(r_count - t_count'(1)));
    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_bottom    = r_bottom;
        n_count     = r_count;
        n_addr_a    = r_addr_a;
        n_addr_b    = r_addr_b;
        n_tmp       = r_tmp;
        n_status    = r_status;
        n_pvalid    = r_pvalid;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_waddr   = r_addr_a;
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = top_slot;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_pvalid = 1'b0;
                    n_state  = S_FIN;
                    case (op)
                        OP_PUSH: begin
                            if (r_count >= t_count'(DEPTH)) begin
                                n_status = ST_OVER;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = f_wrap(r_bottom, r_count);
                                mem_wdata = i_s_tdata;
                                n_count   = t_count'(r_count + t_count'(1));
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_UNDER;
                            end else begin
                                mem_re   = 1'b1;     // data lands in r_rdata for S_FIN
                                n_count  = t_count'(r_count - t_count'(1));
                                n_pvalid = 1'b1;
                            end
                        end
                        OP_SWAP: begin
                            if (r_count >= t_count'(2)) begin
                                mem_re   = 1'b1;
                                n_addr_a = top_slot;
                                n_addr_b = f_wrap(r_bottom, t_count'(r_count - t_count'(2)));
                                n_state  = S_SW_RD2;
                            end
                        end
                        OP_ROT: begin
                            if (r_count >= t_count'(2)) begin
                                mem_re   = 1'b1;
                                n_bottom = (r_bottom == '0) ? t_addr'(DEPTH - 1)
                                                            : t_addr'(r_bottom - t_addr'(1));
                                n_addr_b = n_bottom;
                                n_state  = S_MV_WR;
                            end
                        end
                        OP_RROT: begin
                            if (r_count >= t_count'(2)) begin
                                mem_re    = 1'b1;
                                mem_raddr = r_bottom;
                                n_bottom  = f_wrap(r_bottom, t_count'(1));
                                // new top slot: old bottom + count, wraps onto itself when full
                                n_addr_b  = f_wrap(r_bottom, r_count);
                                n_state   = S_MV_WR;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SW_RD2: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr_b;
                n_tmp     = r_rdata;
                n_state   = S_SW_WA;
            end
            S_SW_WA: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr_a;
                mem_wdata = r_rdata;
                n_state   = S_SW_WB;
            end
            S_SW_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr_b;
                mem_wdata = r_tmp;
                n_state   = S_FIN;
            end
            S_MV_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr_b;
                mem_wdata = r_rdata;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, FILL_W'(r_count),
                                   r_pvalid ? r_rdata : {VAL_W{1'b0}}};
                    n_out_user  = {r_status, r_pvalid};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bottom    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pvalid    <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_bottom    <= n_bottom;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pvalid    <= n_pvalid;
            r_status    <= n_status;
        end
        r_addr_a   <= n_addr_a;
        r_addr_b   <= n_addr_b;
        r_tmp      <= n_tmp;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: src/ssre_checker.sv
module ssre_checker
    import ssre_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [VAL_W-1:0]      i_s_tdata,
    input logic [IN_USER_W-1:0]  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [OUT_USER_W-1:0] o_m_tuser
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in work");

    // underflow leaves an empty stack and no data
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2:1] == ST_UNDER) |->
        (o_m_tuser[0] == 1'b0 && o_m_tdata[VAL_W-1:0] == '0 &&
         o_m_tdata[VAL_W+FILL_W-1:VAL_W] == '0))
        else $error("bad underflow result");

    // a popped value is always a successful operation
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tuser[2:1] == ST_OK))
        else $error("popped value flagged with error status");

    // overflow only when full
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2:1] == ST_OVER) |->
        (o_m_tdata[VAL_W+FILL_W-1:VAL_W] == FILL_W'(DEPTH) && o_m_tuser[0] == 1'b0))
        else $error("overflow reported on a stack that is not full");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
                                         $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind stack_swap_rotate_engine_top ssre_checker u_ssre_checker (.*);

FILE: bench/stack_swap_rotate_engine_top_test.sv
`timescale 1ns / 100ps

module stack_swap_rotate_engine_top_test;
    import ssre_pkg::*;

    // Operation codes the block does not define; they must act as no-ops.
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_TOTAL = 1525;

    typedef struct packed {
        logic [VAL_W-1:0]  popped_value;
        logic              popped_valid;
        t_status           status;
        logic [FILL_W-1:0] fill_count;
    } t_stack_result;

    typedef enum int {
        SINK_OPEN,
        SINK_TWO_OF_THREE,
        SINK_RANDOM,
        SINK_TRICKLE
    } t_sink_mode;

    // Mirror of the stack: same ring layout as the block, results queued in
    // request order.
    class stack_mirror;
        logic [VAL_W-1:0] slots [DEPTH];
        int unsigned      bottom;
        int unsigned      held;
        t_stack_result    pending [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      pushes_ok, pops_ok, overflows, underflows, moves, peak_fill;

        function new();
            bottom     = 0;
            held       = 0;
            mismatches = 0;
            checked    = 0;
            pushes_ok  = 0;
            pops_ok    = 0;
            overflows  = 0;
            underflows = 0;
            moves      = 0;
            peak_fill  = 0;
        endfunction

        function int unsigned slot_at(int unsigned pos);
            return (bottom + pos) % DEPTH;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [2:0] op, logic [VAL_W-1:0] value);
            t_stack_result    res;
            logic [VAL_W-1:0] tmp;
            res = '{popped_value: '0, popped_valid: 1'b0, status: ST_OK, fill_count: '0};
            if (op == OP_PUSH) begin
                if (held >= DEPTH) begin
                    res.status = ST_OVER;
                    overflows++;
                end else begin
                    slots[slot_at(held)] = value;
                    held++;
                    pushes_ok++;
                end
            end else if (op == OP_POP) begin
                if (held == 0) begin
                    res.status = ST_UNDER;
                    underflows++;
                end else begin
                    held--;
                    res.popped_value = slots[slot_at(held)];
                    res.popped_valid = 1'b1;
                    pops_ok++;
                end
            end else if (held >= 2) begin
                case (op)
                    OP_SWAP: begin
                        tmp                    = slots[slot_at(held - 1)];
                        slots[slot_at(held - 1)] = slots[slot_at(held - 2)];
                        slots[slot_at(held - 2)] = tmp;
                        moves++;
                    end
                    OP_ROT: begin
                        // top goes under the bottom
                        tmp           = slots[slot_at(held - 1)];
                        bottom        = (bottom + DEPTH - 1) % DEPTH;
                        slots[bottom] = tmp;
                        moves++;
                    end
                    OP_RROT: begin
                        // bottom goes onto the top
                        tmp                      = slots[bottom];
                        bottom                   = (bottom + 1) % DEPTH;
                        slots[slot_at(held - 1)] = tmp;
                        moves++;
                    end
                    default: ;
                endcase
            end
            if (held > peak_fill) peak_fill = held;
            res.fill_count = held[FILL_W-1:0];
            pending.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_stack_result want;
            t_stack_result got;
            got.popped_value = data[VAL_W-1:0];
            got.fill_count   = data[VAL_W +: FILL_W];
            got.popped_valid = user[0];
            got.status       = t_status'(user[2:1]);
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with no request waiting: value %h fill %0d",
                             checked, got.popped_value, got.fill_count);
                return;
            end
            want = pending.pop_front();
            if (got.popped_value !== want.popped_value || got.popped_valid !== want.popped_valid
                    || got.status !== want.status || got.fill_count !== want.fill_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result %0d mismatch: expected value %h valid %0b status %0d ",
                              "fill %0d, got value %h valid %0b status %0d fill %0d"},
                             checked, want.popped_value, want.popped_valid, want.status,
                             want.fill_count, got.popped_value, got.popped_valid, got.status,
                             got.fill_count);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [VAL_W-1:0]      i_s_tdata;   // [31:0] push_value
    logic [IN_USER_W-1:0]  i_s_tuser;   // [2:0] operation
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [31:0] popped_value, [41:32] fill_count
    logic [OUT_USER_W-1:0] o_m_tuser;   // [0] popped_valid, [2:1] status

    stack_mirror mirror;
    int unsigned burst_left;

    stack_swap_rotate_engine_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: ready follows one of four patterns, each picked at random,
    // from always open down to one cycle in eight.
    initial begin : result_sink
        int unsigned cyc;
        t_sink_mode  mode;
        cyc  = 0;
        mode = SINK_OPEN;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (cyc % 150 == 0) mode = t_sink_mode'($urandom_range(SINK_TRICKLE, SINK_OPEN));
            case (mode)
                SINK_OPEN:         i_m_tready <= 1'b1;
                SINK_TWO_OF_THREE: i_m_tready <= (cyc % 3 != 0);
                SINK_RANDOM:       i_m_tready <= ($urandom_range(9, 0) < 6);
                default:           i_m_tready <= (cyc % 8 == 0);
            endcase
            cyc++;
        end
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid && i_m_tready)
            mirror.check_result(o_m_tdata, o_m_tuser);
    end

    // One request; requests go out in bursts, with an idle gap before most new bursts.
    task automatic send_request(input logic [2:0] op, input logic [VAL_W-1:0] value);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        mirror.note_request(op, value);
        burst_left--;
    endtask

    // Sender holds off until every queued result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (mirror.pending.size() != 0) @(posedge i_clk);
    endtask

    // Mostly random words, with the corner values mixed in.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_op(input int unsigned push_pct, input int unsigned pop_pct);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < push_pct) return OP_PUSH;
        if (r < push_pct + pop_pct) return OP_POP;
        case ($urandom_range(9, 0))
            0, 1, 2: return OP_SWAP;
            3, 4, 5: return OP_ROT;
            6, 7, 8: return OP_RROT;
            default: return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned sent;
        mirror     = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        burst_left = 0;
        sent       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stack, single value, corner values, spare codes,
        // two values where rotate acts as swap, underflow at the end.
        send_request(OP_POP,  pick_value());
        send_request(OP_SWAP, pick_value());
        send_request(OP_ROT,  pick_value());
        send_request(OP_RROT, pick_value());
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_SWAP, pick_value());
        send_request(OP_ROT,  pick_value());
        send_request(OP_RROT, pick_value());
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_SWAP, pick_value());
        send_request(OP_ROT,  pick_value());
        send_request(OP_RROT, pick_value());
        send_request(OP_SPARE_LO,  pick_value());
        send_request(OP_SPARE_MID, pick_value());
        send_request(OP_SPARE_HI,  pick_value());
        send_request(OP_POP,  pick_value());
        send_request(OP_POP,  pick_value());
        send_request(OP_ROT,  pick_value());
        send_request(OP_RROT, pick_value());
        send_request(OP_POP,  pick_value());
        send_request(OP_POP,  pick_value());
        send_request(OP_POP,  pick_value());
        wait_for_results();

        // Fill to the top while shuffling; rotates walk the bottom around the ring.
        while (mirror.held < DEPTH) begin
            send_request(pick_op(85, 5), pick_value());
            sent++;
        end
        // Full: overflow pushes mixed with moves across the ring wrap.
        repeat (12) begin
            send_request(pick_op(50, 0), pick_value());
            sent++;
        end
        wait_for_results();

        // Drain to empty, then poke the empty stack.
        while (mirror.held > 0) begin
            send_request(pick_op(5, 85), pick_value());
            sent++;
        end
        repeat (6) begin
            send_request(pick_op(0, 60), pick_value());
            sent++;
        end
        wait_for_results();

        // Balanced mix at shallow depth.
        while (sent < RANDOM_TOTAL) begin
            send_request(pick_op(35, 30), pick_value());
            sent++;
        end
        wait_for_results();
        repeat (20) @(posedge i_clk);

        $display("%0d results checked: %0d pushes, %0d pops, %0d swaps/rotates, peak fill %0d",
                 mirror.checked, mirror.pushes_ok, mirror.pops_ok, mirror.moves, mirror.peak_fill);
        $display("%0d overflow and %0d underflow requests, %0d mismatches",
                 mirror.overflows, mirror.underflows, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
